@@ src/aes_pkg.sv @@
// aes-128 package: s-box, round constants and round helper functions
package aes_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W = 64;
    localparam int NUM_ROUNDS = 10;

    typedef logic [BLOCK_W-1:0] t_block;

    typedef enum logic [0:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_idx;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tbl [256];
        tbl = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
        return tbl[a];
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the block sits at bits 127-8i
    function automatic logic [7:0] get_b(input t_block s, input int i);
        return s[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BLOCK_W-1-8*(c*4+r) -: 8] = sbox(get_b(s, ((c + r) % 4) * 4 + r));
            end
        end
        return t;
    endfunction

    function automatic t_block mix(input t_block s);
        t_block t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_b(s, c*4);
            a1 = get_b(s, c*4+1);
            a2 = get_b(s, c*4+2);
            a3 = get_b(s, c*4+3);
            t[BLOCK_W-1-8*(c*4)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
            t[BLOCK_W-1-8*(c*4+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
            t[BLOCK_W-1-8*(c*4+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
            t[BLOCK_W-1-8*(c*4+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
        end
        return t;
    endfunction

    function automatic t_block next_key(input t_block k, input logic [3:0] r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

@@ src/aes_round_cell.sv @@
// one round cell: state and its round key, passed to the next cell each cycle that i_en is high
module aes_round_cell #(
    parameter logic [3:0] ROUND = 4'd1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  aes_pkg::t_block i_state,
    input  aes_pkg::t_block i_key,
    output logic            o_valid,
    output aes_pkg::t_block o_state,
    output aes_pkg::t_block o_key
);
    import aes_pkg::*;

    t_block n_key;
    t_block n_state;
    t_block r_state;
    t_block r_key;
    logic   r_valid;

    always_comb begin
        t_block s;
        s = sub_shift(i_state);
        n_key = next_key(i_key, ROUND);
        if (ROUND != 4'(NUM_ROUNDS)) begin
            s = mix(s);
        end
        n_state = s ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule

@@ src/aes128_block_encrypt.sv @@
// aes-128 encryption top level: key registers, round cell chain, output handshake
// an accepted input item is registered in the input cell and then in each round cell before the result is valid
// throughput: one item per cycle while the output is not stalled, one round cell per round plus an input cell
// the chain advances whenever the output stage is empty or being taken
// reset: synchronous active low, clears valid bits and both key registers to zero
// a stall at the output holds the whole chain
module aes128_block_encrypt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_plain_high,
    input  logic [63:0] i_plain_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_cipher_high,
    output logic [63:0] o_cipher_low,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    import aes_pkg::*;

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic        en;
    logic        r_v0;
    t_block      r_s0;
    t_block      r_k0;
    logic        v [NUM_ROUNDS+1];
    t_block      s [NUM_ROUNDS+1];
    t_block      k [NUM_ROUNDS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en = !v[NUM_ROUNDS] || i_ready;
    assign o_ready = en;

    // input cell: initial add round key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
        if (en) begin
            r_s0 <= {i_plain_high, i_plain_low} ^ {r_key_high, r_key_low};
            r_k0 <= {r_key_high, r_key_low};
        end
    end

    assign v[0] = r_v0;
    assign s[0] = r_s0;
    assign k[0] = r_k0;

    for (genvar g = 1; g <= NUM_ROUNDS; g++) begin : g_round
        aes_round_cell #(.ROUND(4'(g))) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g-1]),
            .i_state (s[g-1]),
            .i_key   (k[g-1]),
            .o_valid (v[g]),
            .o_state (s[g]),
            .o_key   (k[g])
        );
    end

    assign o_valid       = v[NUM_ROUNDS];
    assign o_cipher_high = s[NUM_ROUNDS][BLOCK_W-1:HALF_W];
    assign o_cipher_low  = s[NUM_ROUNDS][HALF_W-1:0];

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cipher_high) && $stable(o_cipher_low))
        else $error("result changed while stalled");
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v0)
        else $error("accepted item lost at chain entry");
`endif

endmodule
